@@ design/biquad_coefficient_calculator_top_defines.svh @@
// Assertion macros used by the checker file.
// No dependencies.
`ifndef BIQUAD_COEFFICIENT_CALCULATOR_TOP_DEFINES_SVH
`define BIQUAD_COEFFICIENT_CALCULATOR_TOP_DEFINES_SVH

// Check a property while out of reset.
`define BCC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bcc check failed");

// Check a property at every edge, reset included.
`define BCC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("bcc check failed");

`endif

@@ design/bcc_pkg.sv @@
// Types, codes and arctangent table for the biquad coefficient calculator.
// No dependencies.
package bcc_pkg;

    typedef enum logic [1:0] {
        CFG_RATE = 2'd0,
        CFG_Q    = 2'd1,
        CFG_MODE = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MODE_LP    = 2'd0,
        MODE_HP    = 2'd1,
        MODE_BP    = 2'd2,
        MODE_NOTCH = 2'd3
    } t_mode;

    typedef logic signed [33:0] t_xy;
    typedef logic signed [32:0] t_ang;
    typedef logic signed [47:0] t_wide;

    localparam int ATAN_LEN = 40;
    localparam logic signed [33:0] GAIN_INV = 34'sd652032874;
    localparam logic signed [47:0] ONE_Q30 = 48'sd1073741824;

    localparam logic [31:0] ATAN_TURNS [ATAN_LEN] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
        32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0,
        32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0
    };

endpackage

@@ design/biquad_coefficient_calculator_top.sv @@
// Biquad coefficient calculator: phase divider, CORDIC, alpha divider, coefficient stages.
// Depends on bcc_pkg.
//
// channel   direction  handshake              payload
// cfg       in         i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
// request   in         i_valid/o_ready        i_cutoff_freq
// result    out        o_valid/i_ready        o_coef_b0..o_coef_a2
//
// One beat enters per cycle while the stages advance; a beat passes through the
// 56-step phase divider, the CORDIC stages and the 41-step alpha divider.
// All stages advance together when the output register is empty or taken.
// Reset clears the valid bits and loads the register defaults; no clearing pass.
module biquad_coefficient_calculator_top #(
    parameter int COEF_FRAC_BITS = 28,
    parameter int CORDIC_STAGES  = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [17:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [23:0]        i_cutoff_freq,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_coef_b0,
    output logic signed [31:0] o_coef_b1,
    output logic signed [31:0] o_coef_b2,
    output logic signed [31:0] o_coef_a0,
    output logic signed [31:0] o_coef_a1,
    output logic signed [31:0] o_coef_a2
);
    import bcc_pkg::*;

    localparam int DIV1_N = 56;
    localparam int DIV2_N = 41;
    localparam int LAT    = DIV1_N + CORDIC_STAGES + DIV2_N + 3;
    localparam int SH_R   = (COEF_FRAC_BITS < 31) ? 31 - COEF_FRAC_BITS : 0;
    localparam int SH_L   = (COEF_FRAC_BITS > 31) ? COEF_FRAC_BITS - 31 : 0;
    localparam logic [63:0] RND   = (64'd1 << SH_R) >> 1;
    localparam logic [63:0] L_SAT = 64'h8000_0000 >> SH_L;

    logic [17:0] r_rate;
    logic [15:0] r_q;
    t_mode       r_mode;
    logic [LAT-1:0] r_vld;
    logic        w_adv;
    logic [26:0] w_den;
    logic [15:0] w_qf;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= 18'd48000;
            r_q    <= 16'd181;
            r_mode <= MODE_LP;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_RATE: r_rate <= i_cfg_data;
                CFG_Q:    r_q    <= i_cfg_data[15:0];
                CFG_MODE: r_mode <= t_mode'(i_cfg_data[1:0]);
                default: ;
            endcase
        end
    end

    assign w_adv   = !r_vld[LAT-1] || i_ready;
    assign o_ready = w_adv;
    assign o_valid = r_vld[LAT-1];
    assign w_den   = {1'b0, r_rate, 8'd0};
    assign w_qf    = (r_q == 16'd0) ? 16'd1 : r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // phase divider: low 32 quotient bits of freq * 2^32 / den
    logic [25:0] r_pr [DIV1_N];
    logic [23:0] r_pn [DIV1_N];
    logic [31:0] r_pq [DIV1_N];

    for (genvar g = 0; g < DIV1_N; g++) begin : g_pd
        logic [25:0] w_rem;
        logic [23:0] w_num;
        logic [31:0] w_quo;
        logic [26:0] w_t;
        logic        w_ge;
        if (g == 0) begin : g_first
            assign w_rem = '0;
            assign w_num = i_cutoff_freq;
            assign w_quo = '0;
        end else begin : g_next
            assign w_rem = r_pr[g-1];
            assign w_num = r_pn[g-1];
            assign w_quo = r_pq[g-1];
        end
        assign w_t  = {w_rem, w_num[23]};
        assign w_ge = (w_t >= w_den);
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_pr[g] <= w_ge ? 26'(w_t - w_den) : w_t[25:0];
                r_pn[g] <= {w_num[22:0], 1'b0};
                r_pq[g] <= {w_quo[30:0], w_ge};
            end
        end
    end

    logic [31:0] w_ph;
    assign w_ph = (r_rate == 18'd0) ? 32'd0 : r_pq[DIV1_N-1];

    // CORDIC rotation
    t_xy        r_cx [CORDIC_STAGES];
    t_xy        r_cy [CORDIC_STAGES];
    t_ang       r_cz [CORDIC_STAGES];
    logic [1:0] r_cq [CORDIC_STAGES];

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cd
        t_xy        w_x;
        t_xy        w_y;
        t_ang       w_z;
        logic [1:0] w_qd;
        t_ang       w_at;
        if (g == 0) begin : g_first
            assign w_x  = GAIN_INV;
            assign w_y  = '0;
            assign w_z  = t_ang'({3'd0, w_ph[29:0]});
            assign w_qd = w_ph[31:30];
        end else begin : g_next
            assign w_x  = r_cx[g-1];
            assign w_y  = r_cy[g-1];
            assign w_z  = r_cz[g-1];
            assign w_qd = r_cq[g-1];
        end
        assign w_at = t_ang'({1'b0, ATAN_TURNS[g]});
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                if (!w_z[32]) begin
                    r_cx[g] <= w_x - (w_y >>> g);
                    r_cy[g] <= w_y + (w_x >>> g);
                    r_cz[g] <= w_z - w_at;
                end else begin
                    r_cx[g] <= w_x + (w_y >>> g);
                    r_cy[g] <= w_y - (w_x >>> g);
                    r_cz[g] <= w_z + w_at;
                end
                r_cq[g] <= w_qd;
            end
        end
    end

    // quadrant map and alpha numerator
    t_xy         r_mc;
    t_xy         r_ms;
    logic [40:0] r_mn;
    t_xy         w_c;
    t_xy         w_s;
    t_xy         w_sa;

    always_comb begin
        case (r_cq[CORDIC_STAGES-1])
            2'd0: begin
                w_c = r_cx[CORDIC_STAGES-1];
                w_s = r_cy[CORDIC_STAGES-1];
            end
            2'd1: begin
                w_c = -r_cy[CORDIC_STAGES-1];
                w_s = r_cx[CORDIC_STAGES-1];
            end
            2'd2: begin
                w_c = -r_cx[CORDIC_STAGES-1];
                w_s = -r_cy[CORDIC_STAGES-1];
            end
            default: begin
                w_c = r_cy[CORDIC_STAGES-1];
                w_s = -r_cx[CORDIC_STAGES-1];
            end
        endcase
        w_sa = w_s[33] ? -w_s : w_s;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_mc <= w_c;
            r_ms <= w_s;
            r_mn <= {w_sa[33:0], 7'd0} + 41'(w_qf[15:1]);
        end
    end

    // alpha divider
    logic [15:0] r_ar [DIV2_N];
    logic [40:0] r_an [DIV2_N];
    logic [40:0] r_aq [DIV2_N];
    t_xy         r_ac [DIV2_N];
    t_xy         r_as [DIV2_N];

    for (genvar g = 0; g < DIV2_N; g++) begin : g_ad
        logic [15:0] w_rem;
        logic [40:0] w_num;
        logic [40:0] w_quo;
        t_xy         w_cc;
        t_xy         w_ss;
        logic [16:0] w_t;
        logic        w_ge;
        if (g == 0) begin : g_first
            assign w_rem = '0;
            assign w_num = r_mn;
            assign w_quo = '0;
            assign w_cc  = r_mc;
            assign w_ss  = r_ms;
        end else begin : g_next
            assign w_rem = r_ar[g-1];
            assign w_num = r_an[g-1];
            assign w_quo = r_aq[g-1];
            assign w_cc  = r_ac[g-1];
            assign w_ss  = r_as[g-1];
        end
        assign w_t  = {w_rem, w_num[40]};
        assign w_ge = (w_t >= {1'b0, w_qf});
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_ar[g] <= w_ge ? 16'(w_t - {1'b0, w_qf}) : w_t[15:0];
                r_an[g] <= {w_num[39:0], 1'b0};
                r_aq[g] <= {w_quo[39:0], w_ge};
                r_ac[g] <= w_cc;
                r_as[g] <= w_ss;
            end
        end
    end

    // coefficients in Q31
    t_wide r_b0, r_b1, r_b2, r_a0, r_a1, r_a2;
    t_wide w_c_w, w_s_w, w_al, w_am;
    t_wide n_b0, n_b1, n_b2;

    always_comb begin
        w_c_w = t_wide'(r_ac[DIV2_N-1]);
        w_s_w = t_wide'(r_as[DIV2_N-1]);
        w_am  = t_wide'({7'd0, r_aq[DIV2_N-1]});
        w_al  = w_s_w[47] ? -w_am : w_am;
        case (r_mode)
            MODE_LP: begin
                n_b0 = ONE_Q30 - w_c_w;
                n_b1 = (ONE_Q30 - w_c_w) <<< 1;
                n_b2 = ONE_Q30 - w_c_w;
            end
            MODE_HP: begin
                n_b0 = ONE_Q30 + w_c_w;
                n_b1 = -((ONE_Q30 + w_c_w) <<< 1);
                n_b2 = ONE_Q30 + w_c_w;
            end
            MODE_BP: begin
                n_b0 = w_s_w;
                n_b1 = '0;
                n_b2 = -w_s_w;
            end
            default: begin
                n_b0 = ONE_Q30 <<< 1;
                n_b1 = -(w_c_w <<< 2);
                n_b2 = ONE_Q30 <<< 1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b0 <= n_b0;
            r_b1 <= n_b1;
            r_b2 <= n_b2;
            r_a0 <= (ONE_Q30 + w_al) <<< 1;
            r_a1 <= -(w_c_w <<< 2);
            r_a2 <= (ONE_Q30 - w_al) <<< 1;
        end
    end

    function automatic logic [31:0] to_coef(input t_wide v);
        logic        neg;
        logic [63:0] m;
        logic [63:0] lim;
        neg = v[47];
        m   = {16'd0, neg ? 48'(-v) : 48'(v)};
        lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        if (SH_R > 0) begin
            m = (m + RND) >> SH_R;
        end else if (SH_L > 0) begin
            m = (m > L_SAT) ? 64'h8000_0000 : (m << SH_L);
        end
        if (m > lim) begin
            m = lim;
        end
        return neg ? 32'(64'd0 - m) : m[31:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            o_coef_b0 <= to_coef(r_b0);
            o_coef_b1 <= to_coef(r_b1);
            o_coef_b2 <= to_coef(r_b2);
            o_coef_a0 <= to_coef(r_a0);
            o_coef_a1 <= to_coef(r_a1);
            o_coef_a2 <= to_coef(r_a2);
        end
    end

endmodule

@@ design/bcc_checker.sv @@
// Port-level checks for the biquad coefficient calculator, bound to the top level.
// Depends on biquad_coefficient_calculator_top_defines.svh.
`include "biquad_coefficient_calculator_top_defines.svh"

module bcc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input logic signed [31:0] o_coef_a1
);

    `BCC_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !o_valid)
    `BCC_ASSERT(a_hold_beat, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(o_coef_a1))
    `BCC_ASSERT(a_empty_accepts, i_clk, i_rst_n, !o_valid |-> o_ready)

endmodule

bind biquad_coefficient_calculator_top bcc_checker u_bcc_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .o_ready   (o_ready),
    .o_valid   (o_valid),
    .i_ready   (i_ready),
    .o_coef_a1 (o_coef_a1)
);
